// File: rtl/core/twcd_pkg.sv
// Shared types, constants and the month length table for the two-week calendar grid.
// Depends on nothing; every module of the block imports it.
package twcd_pkg;

  // Allowed grid sizes and the default size.
  localparam int CELLS_MAX          = 14;
  localparam int CELLS_MIN          = 7;
  localparam int GRID_CELLS_DEFAULT = 14;

  // Month and weekday codes.
  localparam logic [3:0] MONTH_JAN  = 4'd0;
  localparam logic [3:0] MONTH_FEB  = 4'd1;
  localparam logic [3:0] MONTH_APR  = 4'd3;
  localparam logic [3:0] MONTH_JUN  = 4'd5;
  localparam logic [3:0] MONTH_SEP  = 4'd8;
  localparam logic [3:0] MONTH_NOV  = 4'd10;
  localparam logic [3:0] MONTH_DEC  = 4'd11;
  localparam logic [2:0] WEEKDAY_SAT = 3'd6;

  // Division of a 12-bit year by one hundred as a reciprocal multiply.
  localparam int          PROD_W       = 25;
  localparam int          QUOT_W       = 6;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;

  // A calendar date inside the grid.
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
  } twcd_date_t;

  // Today's date as requested, carried alongside each date in the chain.
  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] dom;
    logic [3:0] month;
    logic       leap;
  } twcd_ctx_t;

  // Number of days in a month under the Gregorian rule.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      MONTH_FEB: days = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// File: rtl/core/twcd_seed.sv
// Input stage of the calendar grid: captures a request, works out the leap year
// and the date shown in the first cell. Depends on twcd_pkg.
module twcd_seed import twcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req,
  input  logic [2:0]  weekday,
  input  logic [4:0]  day_of_month,
  input  logic [3:0]  month_index,
  input  logic [11:0] full_year,
  output logic        pending,
  output twcd_date_t  seed_date,
  output twcd_ctx_t   seed_ctx
);

  logic [2:0]          wd;
  logic [4:0]          dom;
  logic [3:0]          mon;
  logic [11:0]         year;
  logic [QUOT_W-1:0]   quot;
  logic [PROD_W-1:0]   prod;
  logic [11:0]         hundreds;
  logic                century;
  logic                leap;
  logic [3:0]          prev_month;
  logic [5:0]          wrap_day;

  // The year divided by one hundred, exact over the whole 12-bit range.
  assign prod = PROD_W'(full_year) * PROD_W'(DIV100_MUL);

  // Request capture, with weekday, month and a zero day clamped to legal values.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= req;
    end
    if (req) begin
      wd   <= (weekday > WEEKDAY_SAT) ? WEEKDAY_SAT : weekday;
      dom  <= (day_of_month == 5'd0) ? 5'd1 : day_of_month;
      mon  <= (month_index > MONTH_DEC) ? MONTH_DEC : month_index;
      year <= full_year;
      quot <= prod[DIV100_SHIFT +: QUOT_W];
    end
  end

  // Leap year: divisible by four, and a century year only when divisible by 400.
  assign hundreds = (12'(quot) << 6) + (12'(quot) << 5) + (12'(quot) << 2);
  assign century  = (hundreds == year);
  assign leap     = (year[1:0] == 2'd0) && (!century || (quot[1:0] == 2'd0));

  // The first cell lies weekday days before today, possibly in the month before.
  assign prev_month = (mon == MONTH_JAN) ? MONTH_DEC : mon - 4'd1;
  assign wrap_day   = 6'(month_days(prev_month, leap)) + 6'(dom) - 6'(wd);

  always_comb begin
    if (dom > 5'(wd)) begin
      seed_date.day   = dom - 5'(wd);
      seed_date.month = mon;
    end else begin
      seed_date.day   = wrap_day[4:0];
      seed_date.month = prev_month;
    end
    seed_ctx.weekday = wd;
    seed_ctx.dom     = dom;
    seed_ctx.month   = mon;
    seed_ctx.leap    = leap;
  end

endmodule

// File: rtl/core/twcd_cell.sv
// One cell of the calendar grid chain: holds the date of its grid position and
// hands the date of the following position to its neighbour. Depends on twcd_pkg.
module twcd_cell import twcd_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  twcd_date_t in_date,
  input  twcd_ctx_t  in_ctx,
  output logic       valid,
  output twcd_date_t date,
  output twcd_ctx_t  ctx,
  output twcd_date_t nxt_date
);

  localparam logic [3:0] IDX      = 4'(INDEX);
  localparam logic [3:0] IDX_NEXT = 4'(INDEX + 1);

  logic       before_today;
  logic       today_next;
  logic [5:0] bump;
  logic       over;
  logic       wrap;

  // The date moves one cell along every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
    date <= in_date;
    ctx  <= in_ctx;
  end

  // Before today's cell only a move out of the previous month wraps, so a day
  // given past its month end still counts up to itself.
  assign before_today = IDX < {1'b0, ctx.weekday};
  assign today_next   = IDX_NEXT == {1'b0, ctx.weekday};
  assign bump         = {1'b0, date.day} + 6'd1;
  assign over         = bump > {1'b0, month_days(date.month, ctx.leap)};
  assign wrap         = over && (!before_today || (date.month != ctx.month));

  // Date of the following cell.
  always_comb begin
    if (today_next) begin
      nxt_date.day   = ctx.dom;
      nxt_date.month = ctx.month;
    end else if (wrap) begin
      nxt_date.day   = 5'd1;
      nxt_date.month = (date.month == MONTH_DEC) ? MONTH_JAN : date.month + 4'd1;
    end else begin
      nxt_date.day   = bump[4:0];
      nxt_date.month = date.month;
    end
  end

endmodule

// File: rtl/core/two_week_calendar_days.sv
// Two-week calendar grid: day-of-month numbers for every cell of a grid that
// starts on Sunday, with today in the column of its weekday.
// Depends on twcd_pkg, twcd_seed and twcd_cell.
//
// Use: a request (weekday, day_of_month, month_index, full_year) is taken at a
// rising edge where start is high and busy is low. It yields GRID_CELLS results
// (clamped to 7..14), in cell order, one per cycle on cell_index, cell_day and
// last_cell, each marked by strobe for exactly one cycle; last_cell flags the
// final cell. The receiver cannot stall the results.
// The request passes through the input stage, then the chain of cells that each
// date walks through at one cell per cycle, then the result register. A new
// request is taken before the previous one is through: busy falls while the
// previous request still has results to deliver, so results of successive
// requests follow without a gap.
// Reset: synchronous; it empties the input stage and the chain, and requests
// in flight are dropped. Results from a request never overlap another's.
module two_week_calendar_days import twcd_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  weekday,
  input  logic [4:0]  day_of_month,
  input  logic [3:0]  month_index,
  input  logic [11:0] full_year,
  output logic        strobe,
  output logic [3:0]  cell_index,
  output logic [4:0]  cell_day,
  output logic        last_cell
);

  localparam int CELLS = (GRID_CELLS > CELLS_MAX) ? CELLS_MAX :
                         (GRID_CELLS < CELLS_MIN) ? CELLS_MIN : GRID_CELLS;

  logic             accept;
  logic             seed_pending;
  twcd_date_t       seed_date;
  twcd_ctx_t        seed_ctx;
  logic             chain_valid [CELLS];
  twcd_date_t       chain_date  [CELLS];
  twcd_ctx_t        chain_ctx   [CELLS];
  logic [CELLS-1:0] slot_valid;
  twcd_date_t       slot_date   [CELLS];
  logic             mux_any;
  logic [3:0]       mux_index;
  logic [4:0]       mux_day;
  logic             mux_last;

  assign accept = start && !busy;

  // Input stage: clamps the fields and finds the first cell's date.
  twcd_seed u_seed (
    .clk          (clk),
    .rst          (rst),
    .req          (accept),
    .weekday      (weekday),
    .day_of_month (day_of_month),
    .month_index  (month_index),
    .full_year    (full_year),
    .pending      (seed_pending),
    .seed_date    (seed_date),
    .seed_ctx     (seed_ctx)
  );

  assign chain_valid[0] = seed_pending;
  assign chain_date[0]  = seed_date;
  assign chain_ctx[0]   = seed_ctx;

  // Chain of cells, one per grid position.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k < CELLS - 1) begin : g_mid
      twcd_cell #(.INDEX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_valid (chain_valid[k]),
        .in_date  (chain_date[k]),
        .in_ctx   (chain_ctx[k]),
        .valid    (chain_valid[k+1]),
        .date     (slot_date[k]),
        .ctx      (chain_ctx[k+1]),
        .nxt_date (chain_date[k+1])
      );
      assign slot_valid[k] = chain_valid[k+1];
    end else begin : g_end
      twcd_cell #(.INDEX(k)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .in_valid (chain_valid[k]),
        .in_date  (chain_date[k]),
        .in_ctx   (chain_ctx[k]),
        .valid    (slot_valid[k]),
        .date     (slot_date[k]),
        .ctx      (),
        .nxt_date ()
      );
    end
  end

  // A new request may enter once the previous one has reached the last two cells.
  assign busy = seed_pending || (|slot_valid[CELLS-3:0]);

  // At most one cell is occupied, so its contents are picked by an and-or select.
  always_comb begin
    mux_any   = 1'b0;
    mux_index = '0;
    mux_day   = '0;
    mux_last  = 1'b0;
    for (int k = 0; k < CELLS; k++) begin
      if (slot_valid[k]) begin
        mux_any   = 1'b1;
        mux_index = mux_index | 4'(k);
        mux_day   = mux_day | slot_date[k].day;
        mux_last  = mux_last | (k == CELLS - 1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= mux_any;
    end
    cell_index <= mux_index;
    cell_day   <= mux_day;
    last_cell  <= mux_last;
  end

  // Only one request is ever in the chain.
  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(slot_valid))
    else $error("More than one grid cell is occupied.");

  // A request's first cell passes the input stage, cell 0 and the result register.
  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 (strobe && (cell_index == 4'd0)))
    else $error("First cell of a request did not appear on time.");

  // Cells of one request follow each other without a gap.
  a_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_cell) |=> (strobe && (cell_index == $past(cell_index) + 4'd1)))
    else $error("Cell sequence broken within a request.");

  // The final flag marks the last grid cell only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_cell) |-> (cell_index == 4'(CELLS - 1)))
    else $error("Final flag on the wrong cell.");

  // A day number is never zero.
  a_day: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (cell_day != 5'd0))
    else $error("Zero day number emitted.");

endmodule

// File: verif/two_week_calendar_days_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_week_calendar_days: directed and random date requests,
// with every grid cell checked against a predictor of the calendar walk.
// Depends on twcd_pkg and the two_week_calendar_days RTL.
module two_week_calendar_days_tb import twcd_pkg::*; ();

  // The grid length that the block uses, held within its allowed range.
  localparam int GRID_LEN = (GRID_CELLS_DEFAULT > CELLS_MAX) ? CELLS_MAX :
                            (GRID_CELLS_DEFAULT < CELLS_MIN) ? CELLS_MIN : GRID_CELLS_DEFAULT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_DATES  = 330;
  localparam int SETTLE_CYCLES = 16;

  // Calendar codes that the package does not name.
  localparam logic [2:0] WEEKDAY_SUN = 3'd0;
  localparam logic [2:0] WEEKDAY_TUE = 3'd2;
  localparam logic [2:0] WEEKDAY_WED = 3'd3;
  localparam logic [2:0] WEEKDAY_FRI = 3'd5;
  localparam logic [2:0] WEEKDAY_BAD = 3'd7;
  localparam logic [3:0] MONTH_MAR   = 4'd2;
  localparam logic [3:0] MONTH_MAY   = 4'd4;
  localparam logic [3:0] MONTH_AUG   = 4'd7;
  localparam logic [3:0] MONTH_BAD   = 4'd12;
  localparam logic [3:0] MONTH_TOP   = 4'd15;

  typedef struct packed {
    logic [3:0] index;
    logic [4:0] day;
    logic       last;
  } grid_cell_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  weekday = '0;
  logic [4:0]  day_of_month = '0;
  logic [3:0]  month_index = '0;
  logic [11:0] full_year = '0;
  logic        busy;
  logic        strobe;
  logic [3:0]  cell_index;
  logic [4:0]  cell_day;
  logic        last_cell;

  grid_cell_t  expected_cells[$];
  grid_cell_t  want_cell;
  int          mismatches = 0;
  int          cycle_count = 0;

  two_week_calendar_days #(
    .GRID_CELLS(GRID_CELLS_DEFAULT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .weekday(weekday),
    .day_of_month(day_of_month),
    .month_index(month_index),
    .full_year(full_year),
    .strobe(strobe),
    .cell_index(cell_index),
    .cell_day(cell_day),
    .last_cell(last_cell)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Month length: odd months are short up to July and long from August on.
  function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
    if (month == MONTH_FEB) return leap ? 29 : 28;
    return 31 - ((month ^ ((month >= MONTH_AUG) ? 1 : 0)) & 1);
  endfunction

  function automatic bit gregorian_leap(input int unsigned year);
    return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
  endfunction

  // Walks forward and back from today and queues the day shown in every cell.
  function automatic void predict_grid_days(input logic [2:0] wd_in, input logic [4:0] dom_in,
                                            input logic [3:0] mon_in, input logic [11:0] year);
    int unsigned today_col, dom, mon, d, m, i;
    bit          leap;
    int unsigned days [GRID_LEN];
    grid_cell_t  entry;
    today_col = (wd_in > WEEKDAY_SAT) ? WEEKDAY_SAT : wd_in;
    mon       = (mon_in > MONTH_DEC) ? MONTH_DEC : mon_in;
    dom       = (dom_in == 0) ? 1 : dom_in;
    leap      = gregorian_leap(year);

    // Today and the cells after it.
    d = dom;
    m = mon;
    for (i = today_col; i < GRID_LEN; i++) begin
      days[i] = d;
      d++;
      if (d > days_in_month(m, leap)) begin
        d = 1;
        m = (m == MONTH_DEC) ? MONTH_JAN : m + 1;
      end
    end

    // The cells before today.
    d = dom;
    m = mon;
    for (i = today_col; i > 0; i--) begin
      d--;
      if (d == 0) begin
        m = (m == MONTH_JAN) ? MONTH_DEC : m - 1;
        d = days_in_month(m, leap);
      end
      days[i - 1] = d;
    end

    for (i = 0; i < GRID_LEN; i++) begin
      entry.index = i[3:0];
      entry.day   = days[i][4:0];
      entry.last  = (i + 1 == GRID_LEN);
      expected_cells.push_back(entry);
    end
  endfunction

  // Each strobed result is compared with the oldest expected cell.
  always @(posedge clk) begin
    if (!rst && strobe !== 1'b0) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result: cell_index %0d cell_day %0d last_cell %0b",
               cell_index, cell_day, last_cell);
        mismatches++;
      end else begin
        want_cell = expected_cells.pop_front();
        if (strobe !== 1'b1) begin
          $error("strobe: expected 1, got %b", strobe);
          mismatches++;
        end
        if (cell_index !== want_cell.index) begin
          $error("cell_index: expected %0d, got %0d", want_cell.index, cell_index);
          mismatches++;
        end
        if (cell_day !== want_cell.day) begin
          $error("cell_day: expected %0d, got %0d", want_cell.day, cell_day);
          mismatches++;
        end
        if (last_cell !== want_cell.last) begin
          $error("last_cell: expected %0b, got %0b", want_cell.last, last_cell);
          mismatches++;
        end
      end
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_date(input logic [2:0] wd, input logic [4:0] dom,
                           input logic [3:0] mon, input logic [11:0] year);
    @(negedge clk);
    start        <= 1'b1;
    weekday      <= wd;
    day_of_month <= dom;
    month_index  <= mon;
    full_year    <= year;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_grid_days(wd, dom, mon, year);
  endtask

  // Drops start for a while, with junk on the request fields.
  task automatic idle_cycles(input int n);
    @(negedge clk);
    start        <= 1'b0;
    weekday      <= 3'($urandom);
    day_of_month <= 5'($urandom);
    month_index  <= 4'($urandom);
    full_year    <= 12'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 12) idle_cycles($urandom_range(1, 20));
  endtask

  // Holds off further requests until every queued cell has come out.
  task automatic wait_for_grid_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
  endtask

  // Wrapping across month and year boundaries.
  task automatic test_month_and_year_ends();
    send_date(WEEKDAY_SAT, 5'd1, MONTH_JAN, 12'd2000);
    maybe_idle();
    send_date(WEEKDAY_SUN, 5'd31, MONTH_DEC, 12'd1999);
    maybe_idle();
    send_date(WEEKDAY_WED, 5'd30, MONTH_APR, 12'd2021);
    send_date(WEEKDAY_SUN, 5'd1, MONTH_MAR, 12'd2021);
    send_date(WEEKDAY_SAT, 5'd31, MONTH_AUG, 12'd2022);
  endtask

  // February under the four, hundred and four-hundred year rules.
  task automatic test_leap_rule();
    send_date(WEEKDAY_WED, 5'd28, MONTH_FEB, 12'd2000);
    send_date(WEEKDAY_WED, 5'd28, MONTH_FEB, 12'd1900);
    maybe_idle();
    send_date(WEEKDAY_TUE, 5'd28, MONTH_FEB, 12'd2024);
    send_date(WEEKDAY_TUE, 5'd28, MONTH_FEB, 12'd2023);
    send_date(WEEKDAY_FRI, 5'd1, MONTH_MAR, 12'd2024);
    send_date(WEEKDAY_FRI, 5'd1, MONTH_MAR, 12'd2100);
    send_date(WEEKDAY_SUN, 5'd29, MONTH_FEB, 12'd0);
    send_date(WEEKDAY_SUN, 5'd28, MONTH_FEB, 12'd4095);
    send_date(WEEKDAY_SUN, 5'd28, MONTH_FEB, 12'd4000);
    wait_for_grid_drain();
  endtask

  // Saturated weekday and month, day zero and days past the month end.
  task automatic test_out_of_range_fields();
    send_date(WEEKDAY_BAD, 5'd15, MONTH_MAY, 12'd2021);
    send_date(WEEKDAY_WED, 5'd10, MONTH_TOP, 12'd2021);
    maybe_idle();
    send_date(WEEKDAY_WED, 5'd20, MONTH_BAD, 12'd2021);
    send_date(WEEKDAY_SUN, 5'd0, MONTH_JAN, 12'd2021);
    send_date(WEEKDAY_SAT, 5'd0, MONTH_MAR, 12'd2024);
    send_date(WEEKDAY_SUN, 5'd31, MONTH_APR, 12'd2021);
    send_date(WEEKDAY_SAT, 5'd31, MONTH_FEB, 12'd2023);
    send_date(WEEKDAY_SUN, 5'd31, MONTH_FEB, 12'd2024);
    send_date(WEEKDAY_BAD, 5'd31, MONTH_TOP, 12'd4095);
    send_date(WEEKDAY_SUN, 5'd0, MONTH_JAN, 12'd0);
  endtask

  // Mostly valid dates biased towards month edges and century years, some noise.
  task automatic test_random_dates();
    int          n, len;
    logic [2:0]  wd;
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [11:0] year;
    for (n = 0; n < RANDOM_DATES; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        mon  = 4'($urandom_range(0, 11));
        year = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 40) * 100)
                                            : 12'($urandom_range(0, 4095));
        len  = days_in_month(mon, gregorian_leap(year));
        case ($urandom_range(0, 3))
          0: dom = 5'($urandom_range(1, 3));
          1: dom = 5'($urandom_range(len - 2, len));
          default: dom = 5'($urandom_range(1, len));
        endcase
        wd = 3'($urandom_range(0, 6));
      end else begin
        wd   = 3'($urandom_range(0, 7));
        dom  = 5'($urandom_range(0, 31));
        mon  = 4'($urandom_range(0, 15));
        year = 12'($urandom_range(0, 4095));
      end
      // A long back-to-back stretch in the middle, and one full drain after it.
      if (n == 240) wait_for_grid_drain();
      else if (n < 120 || n >= 220) maybe_idle();
      send_date(wd, dom, mon, year);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_month_and_year_ends();
    test_leap_rule();
    test_out_of_range_fields();
    test_random_dates();
    @(negedge clk);
    start <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
